@@ rtl/pps_pkg.sv @@
package pps_pkg;

  localparam int MAX_PROCS_DEF     = 16;
  localparam int NONE_PRIORITY_DEF = 999;
  localparam int TIME_W            = 16;
  localparam int PRIO_W            = 10;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // sequencer steps
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] S_IDLE = 3'd0;
  localparam logic [STEP_W-1:0] S_LOAD = 3'd1;
  localparam logic [STEP_W-1:0] S_INIT = 3'd2;
  localparam logic [STEP_W-1:0] S_SCAN = 3'd3;
  localparam logic [STEP_W-1:0] S_UPD  = 3'd4;

  // datapath operations
  localparam logic [2:0] OP_NOP    = 3'd0;
  localparam logic [2:0] OP_LOAD   = 3'd1;
  localparam logic [2:0] OP_INIT   = 3'd2;
  localparam logic [2:0] OP_SCAN   = 3'd3;
  localparam logic [2:0] OP_UPDATE = 3'd4;

  // jump conditions
  localparam logic [2:0] JC_ALWAYS   = 3'd0;
  localparam logic [2:0] JC_DISPATCH = 3'd1;
  localparam logic [2:0] JC_EMPTY    = 3'd2;
  localparam logic [2:0] JC_SCAN_END = 3'd3;
  localparam logic [2:0] JC_OUT_FREE = 3'd4;

  typedef struct packed {
    logic              in_ready;
    logic [2:0]        op;
    logic [2:0]        cond;
    logic              hold;     // on a false condition: stay, else fall through
    logic [STEP_W-1:0] target;
  } ucode_t;

  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '{in_ready: 1'b0, op: OP_NOP, cond: JC_ALWAYS, hold: 1'b0, target: S_IDLE};
    case (step)
      S_IDLE: w = '{in_ready: 1'b1, op: OP_NOP,    cond: JC_DISPATCH, hold: 1'b1,
                    target: S_IDLE};
      S_LOAD: w = '{in_ready: 1'b0, op: OP_LOAD,   cond: JC_ALWAYS,   hold: 1'b0,
                    target: S_IDLE};
      S_INIT: w = '{in_ready: 1'b0, op: OP_INIT,   cond: JC_EMPTY,    hold: 1'b0,
                    target: S_UPD};
      S_SCAN: w = '{in_ready: 1'b0, op: OP_SCAN,   cond: JC_SCAN_END, hold: 1'b1,
                    target: S_UPD};
      S_UPD:  w = '{in_ready: 1'b0, op: OP_UPDATE, cond: JC_OUT_FREE, hold: 1'b1,
                    target: S_IDLE};
      default: w = '{in_ready: 1'b0, op: OP_NOP,   cond: JC_ALWAYS,   hold: 1'b0,
                    target: S_IDLE};
    endcase
    return w;
  endfunction

  function automatic int id_width(input int n);
    return $clog2(n + 1);
  endfunction

  function automatic int pad8(input int n);
    return ((n + 7) / 8) * 8;
  endfunction

endpackage

@@ rtl/pps_ram.sv @@
module pps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/preemptive_priority_scheduler_core.sv @@
// Preemptive priority scheduler. Input transactions either append a process
// (tuser = 0: arrival, burst, priority) to a table of MAX_PROCS entries, or
// advance time by one tick (tuser = 1). A load into a full table is dropped.
// Each tick serves the arrived, unfinished process with the numerically
// lowest priority below NONE_PRIORITY (lowest index on a tie), takes one
// tick off its remaining time and emits one result transaction; loads emit
// nothing. Time saturates at 65535. A new transaction is accepted only in the
// idle step. A tick's scan reads one table entry per cycle from the single
// process RAM. A tick waits in its last step only if the previous result
// has not yet been taken. Loads are still accepted while a result waits.
// Table entries are stored without reset; only loaded entries are ever used.
module preemptive_priority_scheduler_core
  import pps_pkg::*;
#(
  parameter int MAX_PROCS     = MAX_PROCS_DEF,
  parameter int NONE_PRIORITY = NONE_PRIORITY_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // [15:0] arrival, [31:16] burst, [41:32] priority_req, zero padding above
  input  logic [pad8(2*TIME_W+PRIO_W)-1:0] s_axis_tdata,
  // [0] mode
  input  logic s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // from bit 0 up: tick_time, running_id, segment_start, finished,
  // finished_id, completion_time, turnaround, waiting, all_done, zero padding
  output logic [pad8(4*TIME_W+3+2*id_width(MAX_PROCS))-1:0] m_axis_tdata
);

  localparam int AW     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int ID_W   = id_width(MAX_PROCS);
  localparam int CNT_W  = id_width(MAX_PROCS);
  localparam int WORD_W = 3*TIME_W + PRIO_W;
  localparam int OUT_W  = 4*TIME_W + 3 + 2*ID_W;
  localparam int OUT_TW = pad8(OUT_W);

  // sequencer
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  ucode_t            uc;
  logic              cond_true;

  // latched load fields
  logic [TIME_W-1:0] ld_arrival;
  logic [TIME_W-1:0] ld_burst;
  logic [PRIO_W-1:0] ld_prio;

  // scheduler state
  logic [CNT_W-1:0]  loaded_count;
  logic [CNT_W-1:0]  done_count;
  logic [TIME_W-1:0] cur_time;
  logic [ID_W-1:0]   last_served;
  logic              first_tick;

  // scan state: best candidate so far and its table word
  logic [AW-1:0]     idx;
  logic [PRIO_W-1:0] best;
  logic              found;
  logic [AW-1:0]     pick;
  logic [TIME_W-1:0] p_arr;
  logic [TIME_W-1:0] p_burst;
  logic [PRIO_W-1:0] p_prio;
  logic [TIME_W-1:0] p_rem;

  // process RAM: {remaining, priority, burst, arrival}
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;
  logic [TIME_W-1:0] rd_arr;
  logic [TIME_W-1:0] rd_burst;
  logic [PRIO_W-1:0] rd_prio;
  logic [TIME_W-1:0] rd_rem;

  logic              s_acc;
  logic              out_free;
  logic              upd_go;
  logic              load_room;
  logic              scan_end;
  logic              better;

  // tick results
  logic [TIME_W-1:0] time_next;
  logic [TIME_W-1:0] rem_dec;
  logic              fin;
  logic [ID_W-1:0]   run_id;
  logic [CNT_W-1:0]  done_next;
  logic [TIME_W-1:0] tat;
  logic [TIME_W-1:0] wt;
  logic [OUT_W-1:0]  out_word;
  logic [OUT_TW-1:0] out_data;
  logic              out_valid;

  assign uc            = ucode_rom(step);
  assign s_axis_tready = uc.in_ready;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;
  assign upd_go        = (uc.op == OP_UPDATE) && out_free;
  assign load_room     = loaded_count < CNT_W'(MAX_PROCS);
  assign scan_end      = (CNT_W'(idx) + CNT_W'(1)) == loaded_count;

  always_comb begin
    case (uc.cond)
      JC_ALWAYS:   cond_true = 1'b1;
      JC_DISPATCH: cond_true = s_acc;
      JC_EMPTY:    cond_true = (loaded_count == '0);
      JC_SCAN_END: cond_true = scan_end;
      JC_OUT_FREE: cond_true = out_free;
      default:     cond_true = 1'b1;
    endcase
  end

  // Dispatch decodes the transaction kind; every other jump goes to target.
  always_comb begin
    if (cond_true) begin
      if (uc.cond == JC_DISPATCH) begin
        step_next = s_axis_tuser ? S_INIT : S_LOAD;
      end else begin
        step_next = uc.target;
      end
    end else if (uc.hold) begin
      step_next = step;
    end else begin
      step_next = step + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_IDLE;
    end else begin
      step <= step_next;
    end
  end

  // RAM ports: one write (load or remaining-time update), one scan read
  assign {rd_rem, rd_prio, rd_burst, rd_arr} = ram_rdata;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pick;
    ram_wdata = {rem_dec, p_prio, p_burst, p_arr};
    if (uc.op == OP_LOAD) begin
      ram_we    = load_room;
      ram_waddr = loaded_count[AW-1:0];
      ram_wdata = {ld_burst, ld_prio, ld_burst, ld_arrival};
    end else if (upd_go) begin
      ram_we = found;
    end
  end

  assign ram_raddr = (uc.op == OP_SCAN) ? AW'(idx + AW'(1)) : '0;

  pps_ram #(
    .WIDTH(WORD_W),
    .DEPTH(MAX_PROCS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (s_acc) begin
      ld_arrival <= s_axis_tdata[TIME_W-1:0];
      ld_burst   <= s_axis_tdata[2*TIME_W-1:TIME_W];
      ld_prio    <= s_axis_tdata[2*TIME_W+PRIO_W-1:2*TIME_W];
    end
  end

  // candidate test for the entry read last cycle
  assign better = (rd_arr <= cur_time) && (rd_rem != '0) && (rd_prio < best);

  always_ff @(posedge clk) begin
    if (uc.op == OP_INIT) begin
      idx  <= '0;
      best <= PRIO_W'(NONE_PRIORITY);
    end else if (uc.op == OP_SCAN) begin
      idx <= AW'(idx + AW'(1));
      if (better) begin
        best    <= rd_prio;
        pick    <= idx;
        p_arr   <= rd_arr;
        p_burst <= rd_burst;
        p_prio  <= rd_prio;
        p_rem   <= rd_rem;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (uc.op == OP_INIT) begin
      found <= 1'b0;
    end else if ((uc.op == OP_SCAN) && better) begin
      found <= 1'b1;
    end
  end

  // tick arithmetic
  assign time_next = (cur_time == TIME_MAX) ? cur_time : cur_time + TIME_W'(1);
  assign rem_dec   = p_rem - TIME_W'(1);
  assign fin       = found && (rem_dec == '0);
  assign run_id    = found ? ID_W'(pick) + ID_W'(1) : '0;
  assign done_next = fin ? done_count + CNT_W'(1) : done_count;
  assign tat       = fin ? time_next - p_arr : '0;
  // only negative once time has saturated; clamp to zero
  assign wt        = (fin && (tat >= p_burst)) ? tat - p_burst : '0;

  assign out_word = {
    (done_next == loaded_count),
    wt,
    tat,
    fin ? time_next : TIME_W'(0),
    fin ? run_id : ID_W'(0),
    fin,
    (first_tick || (last_served != run_id)),
    run_id,
    cur_time
  };

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded_count <= '0;
      done_count   <= '0;
      cur_time     <= '0;
      last_served  <= '0;
      first_tick   <= 1'b1;
    end else begin
      if ((uc.op == OP_LOAD) && load_room) begin
        loaded_count <= loaded_count + CNT_W'(1);
      end
      if (upd_go) begin
        done_count  <= done_next;
        cur_time    <= time_next;
        last_served <= run_id;
        first_tick  <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (upd_go) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_go) begin
      out_data <= OUT_TW'(out_word);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule

@@ rtl/pps_checker.sv @@
module pps_checker
  import pps_pkg::*;
#(
  parameter int MAX_PROCS = MAX_PROCS_DEF
) (
  input logic clk,
  input logic rst,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [pad8(4*TIME_W+3+2*id_width(MAX_PROCS))-1:0] m_axis_tdata
);

  localparam int ID_W    = id_width(MAX_PROCS);
  localparam int RUN_LO  = TIME_W;
  localparam int SEG_B   = TIME_W + ID_W;
  localparam int FIN_B   = SEG_B + 1;
  localparam int FID_LO  = FIN_B + 1;

  logic              out_acc;
  logic [TIME_W-1:0] o_time;
  logic [ID_W-1:0]   o_run;
  logic              o_seg;
  logic              o_fin;
  logic [ID_W-1:0]   o_fid;
  logic [TIME_W-1:0] prev_time;
  logic [ID_W-1:0]   prev_run;
  logic              seen;

  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign o_time  = m_axis_tdata[TIME_W-1:0];
  assign o_run   = m_axis_tdata[RUN_LO+ID_W-1:RUN_LO];
  assign o_seg   = m_axis_tdata[SEG_B];
  assign o_fin   = m_axis_tdata[FIN_B];
  assign o_fid   = m_axis_tdata[FID_LO+ID_W-1:FID_LO];

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= 1'b0;
    end else if (out_acc) begin
      seen <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_acc) begin
      prev_time <= o_time;
      prev_run  <= o_run;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  a_tick_step: assert property (@(posedge clk) disable iff (rst)
    out_acc && seen |->
      o_time == ((prev_time == TIME_MAX) ? prev_time : prev_time + TIME_W'(1)))
    else $error("tick time did not advance by one");

  a_segment: assert property (@(posedge clk) disable iff (rst)
    out_acc |-> o_seg == (!seen || (o_run != prev_run)))
    else $error("segment start flag wrong");

  a_finish_id: assert property (@(posedge clk) disable iff (rst)
    out_acc && o_fin |-> (o_fid == o_run) && (o_run != '0))
    else $error("completion does not match served process");

endmodule

bind preemptive_priority_scheduler_core pps_checker #(
  .MAX_PROCS(MAX_PROCS)
) u_pps_checker (.*);
